### design/vertex_transform_project_macros.svh
// assertion macros shared by the checker
`ifndef VERTEX_TRANSFORM_PROJECT_MACROS_SVH
`define VERTEX_TRANSFORM_PROJECT_MACROS_SVH

// clocked assertion, masked while reset is held
`define VTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must follow a stalled result transaction
`define VTP_ASSERT_HELD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (out_valid && out_stall) |=> prop) else $error(msg);

`endif

### design/vtp_pkg.sv
// shared types and constants for the vertex transform and projection block
package vtp_pkg;

  // input transaction: one homogeneous vertex
  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] vertex_w;
  } in_data_t;

  // result transaction: screen position
  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               clip_w_zero;
  } out_data_t;

  // per-vertex flags carried alongside the divide
  typedef struct packed {
    logic w_zero;
    logic x_neg;
    logic y_neg;
  } vtp_flags_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROW0      = 3'd0,
    CFG_ROW1      = 3'd1,
    CFG_ROW2      = 3'd2,
    CFG_ROW3      = 3'd3,
    CFG_VP_WIDTH  = 3'd4,
    CFG_VP_HEIGHT = 3'd5
  } cfg_idx_t;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

endpackage

### design/vtp_lane.sv
// one matrix row dot product lane: multiply, sum, truncate and saturate
module vtp_lane
  import vtp_pkg::*;
#(
  parameter int MFB = 12
) (
  input  logic                clk,
  input  logic                en,
  input  logic [63:0]         row,
  input  in_data_t            vtx,
  output logic signed [31:0]  clip
);

  localparam logic signed [49:0] RND = 50'((64'sd1 <<< MFB) - 64'sd1);

  logic signed [15:0] m [4];
  logic signed [31:0] v [4];
  logic signed [47:0] prod_r [4];
  logic signed [49:0] sum_r;
  logic signed [49:0] adj;
  logic signed [49:0] shq;
  logic signed [31:0] clip_r;

  // operand selection
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      m[c] = row[16*c +: 16];
    end
    v[0] = vtx.vertex_x;
    v[1] = vtx.vertex_y;
    v[2] = vtx.vertex_z;
    v[3] = vtx.vertex_w;
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[c] <= m[c] * v[c];
      end
    end
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= 50'(prod_r[0]) + 50'(prod_r[1]) + 50'(prod_r[2]) + 50'(prod_r[3]);
    end
  end

  // scale down toward zero
  assign adj = sum_r + (sum_r[49] ? RND : 50'sd0);
  assign shq = adj >>> MFB;

  // saturate to 32 bits
  always_ff @(posedge clk) begin
    if (en) begin
      if (shq > 50'(S32_MAX)) begin
        clip_r <= S32_MAX;
      end else if (shq < 50'(S32_MIN)) begin
        clip_r <= S32_MIN;
      end else begin
        clip_r <= shq[31:0];
      end
    end
  end

  assign clip = clip_r;

endmodule

### design/vtp_div.sv
// pipelined signed divider: (num << CF) / den, one quotient bit per stage
module vtp_div
  import vtp_pkg::*;
#(
  parameter int CF = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo
);

  localparam int DW = 32 + CF;

  logic [31:0]    rem_r [0:DW-1];
  logic [31:0]    b_r   [0:DW-1];
  logic [DW-1:0]  aq_r  [0:DW];
  logic           neg_r [0:DW];
  logic [31:0]    num_mag;
  logic [31:0]    den_mag;
  logic [DW-1:0]  qf;
  logic signed [31:0] quo_r;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign den_mag = den[31] ? 32'(-den) : 32'(den);

  // load magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      b_r[0]   <= den_mag;
      aq_r[0]  <= {num_mag, {CF{1'b0}}};
      neg_r[0] <= num[31] ^ den[31];
    end
  end

  // restoring stages
  genvar k;
  for (k = 0; k < DW; k++) begin : g_stg
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_r[k], aq_r[k][DW-1]};
    assign ge    = trial >= {1'b0, b_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        aq_r[k+1]  <= {aq_r[k][DW-2:0], ge};
        neg_r[k+1] <= neg_r[k];
      end
    end
    if (k < DW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? 32'(trial - {1'b0, b_r[k]}) : trial[31:0];
          b_r[k+1]   <= b_r[k];
        end
      end
    end
  end

  assign qf = aq_r[DW];

  // sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (!neg_r[DW]) begin
        quo_r <= (|qf[DW-1:31]) ? S32_MAX : qf[31:0];
      end else if ((|qf[DW-1:32]) || (qf[31] && (|qf[30:0]))) begin
        quo_r <= S32_MIN;
      end else begin
        quo_r <= 32'(-qf[31:0]);
      end
    end
  end

  assign quo = quo_r;

endmodule

### design/vtp_vp.sv
// merge stage: viewport scaling, halving, saturation and zero-w override
module vtp_vp
  import vtp_pkg::*;
#(
  parameter int CF = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ndc_x,
  input  logic signed [31:0] ndc_y,
  input  vtp_flags_t         flags,
  input  logic [13:0]        vp_width,
  input  logic [13:0]        vp_height,
  output out_data_t          result
);

  localparam logic signed [32:0] ONE = 33'(64'sd1 <<< CF);

  logic signed [47:0] px_r;
  logic signed [47:0] py_r;
  vtp_flags_t         fl_r;
  logic signed [47:0] hx;
  logic signed [47:0] hy;
  out_data_t          res_r;

  // offset and scale
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= (33'(ndc_x) + ONE) * $signed({1'b0, vp_width});
      py_r <= (ONE - 33'(ndc_y)) * $signed({1'b0, vp_height});
      fl_r <= flags;
    end
  end

  // halve toward zero
  assign hx = (px_r + (px_r[47] ? 48'sd1 : 48'sd0)) >>> 1;
  assign hy = (py_r + (py_r[47] ? 48'sd1 : 48'sd0)) >>> 1;

  // saturate, or force the zero-w answer
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.clip_w_zero <= fl_r.w_zero;
      if (fl_r.w_zero) begin
        res_r.screen_x <= fl_r.x_neg ? S32_MIN : S32_MAX;
        res_r.screen_y <= fl_r.y_neg ? S32_MAX : S32_MIN;
      end else begin
        if (hx > 48'(S32_MAX)) begin
          res_r.screen_x <= S32_MAX;
        end else if (hx < 48'(S32_MIN)) begin
          res_r.screen_x <= S32_MIN;
        end else begin
          res_r.screen_x <= hx[31:0];
        end
        if (hy > 48'(S32_MAX)) begin
          res_r.screen_y <= S32_MAX;
        end else if (hy < 48'(S32_MIN)) begin
          res_r.screen_y <= S32_MIN;
        end else begin
          res_r.screen_y <= hy[31:0];
        end
      end
    end
  end

  assign result = res_r;

endmodule

### design/vertex_transform_project.sv
// top level: vertex transform, perspective divide and viewport mapping
//
// in_valid/in_stall/in_data carry one vertex (x, y, z, w, signed Q16.16) per
// transaction; out_valid/out_stall/out_data return one screen position per
// vertex, in order. A transaction moves when valid is high and stall is low.
// cfg_valid/cfg_ready/cfg_index/cfg_data write matrix rows 0, 1 and 3 and
// the viewport width (4) and height (5); cfg_ready is always high, and
// row 2 and other indexes are dropped. Write configuration only while the
// pipeline is empty. The row dot products register their products, sum and
// saturated result; the two divides by clip w follow, resolving one quotient
// bit per stage, and then the viewport stage and output register. One
// vertex is accepted every cycle while the pipeline is not stalled.
// When the receiver stalls while a result is held, the whole pipeline
// freezes and in_stall is raised in the same cycle.
// Synchronous reset empties the pipeline and loads the identity matrix and a
// 320 by 200 viewport.
module vertex_transform_project
  import vtp_pkg::*;
#(
  parameter int COORD_FRAC_BITS  = 16,
  parameter int MATRIX_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_data_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int DIV_LAT = 32 + COORD_FRAC_BITS + 2;
  localparam int VLD_N   = 3 + DIV_LAT + 1;
  localparam logic [63:0] DIAG = 64'd1 << MATRIX_FRAC_BITS;

  logic               en;
  logic [63:0]        row0_r;
  logic [63:0]        row1_r;
  logic [63:0]        row3_r;
  logic [13:0]        vp_w_r;
  logic [13:0]        vp_h_r;
  logic               vld_r [0:VLD_N-1];
  logic               out_valid_r;
  vtp_flags_t         fl_r [0:DIV_LAT-1];
  logic signed [31:0] clip_x;
  logic signed [31:0] clip_y;
  logic signed [31:0] clip_w;
  logic signed [31:0] ndc_x;
  logic signed [31:0] ndc_y;

  // pipeline advances unless a held result is stalled
  assign in_stall  = out_valid_r & out_stall;
  assign en        = ~in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= DIAG;
      row1_r <= DIAG << 16;
      row3_r <= DIAG << 48;
      vp_w_r <= 14'd320;
      vp_h_r <= 14'd200;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROW0:      row0_r <= cfg_data;
        CFG_ROW1:      row1_r <= cfg_data;
        CFG_ROW2:      ;
        CFG_ROW3:      row3_r <= cfg_data;
        CFG_VP_WIDTH:  vp_w_r <= cfg_data[13:0];
        CFG_VP_HEIGHT: vp_h_r <= cfg_data[13:0];
        default:       ;
      endcase
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VLD_N; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < VLD_N; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[VLD_N-1];
    end
  end

  // row lanes for clip x, y and w
  vtp_lane #(.MFB(MATRIX_FRAC_BITS)) u_lane_x (
    .clk(clk), .en(en), .row(row0_r), .vtx(in_data), .clip(clip_x)
  );
  vtp_lane #(.MFB(MATRIX_FRAC_BITS)) u_lane_y (
    .clk(clk), .en(en), .row(row1_r), .vtx(in_data), .clip(clip_y)
  );
  vtp_lane #(.MFB(MATRIX_FRAC_BITS)) u_lane_w (
    .clk(clk), .en(en), .row(row3_r), .vtx(in_data), .clip(clip_w)
  );

  // flags ride alongside the divides
  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= '{w_zero: (clip_w == 32'sd0), x_neg: clip_x[31], y_neg: clip_y[31]};
      for (int i = 1; i < DIV_LAT; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  // perspective divides
  vtp_div #(.CF(COORD_FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .num(clip_x), .den(clip_w), .quo(ndc_x)
  );
  vtp_div #(.CF(COORD_FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .num(clip_y), .den(clip_w), .quo(ndc_y)
  );

  // viewport merge and output register
  vtp_vp #(.CF(COORD_FRAC_BITS)) u_vp (
    .clk(clk),
    .en(en),
    .ndc_x(ndc_x),
    .ndc_y(ndc_y),
    .flags(fl_r[DIV_LAT-1]),
    .vp_width(vp_w_r),
    .vp_height(vp_h_r),
    .result(out_data)
  );

  assign out_valid = out_valid_r;

endmodule

### design/vtp_checker.sv
// port-level checker for the vertex transform block, with its bind
`include "vertex_transform_project_macros.svh"

module vtp_checker
  import vtp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_data_t out_data
);

  logic x_sat;
  logic y_sat;

  // whether each screen coordinate is at a saturation bound
  assign x_sat = (out_data.screen_x == S32_MAX) || (out_data.screen_x == S32_MIN);
  assign y_sat = (out_data.screen_y == S32_MAX) || (out_data.screen_y == S32_MIN);

  // a stalled result stays offered and unchanged
  `VTP_ASSERT_HELD(a_out_hold, out_valid, "stalled result dropped")
  `VTP_ASSERT_HELD(a_out_stable, $stable(out_data), "stalled result changed")

  // input is held back exactly while a result is stalled
  `VTP_ASSERT(a_in_stall, in_stall == (out_valid && out_stall), "input stall mismatch")

  // zero w gives saturated coordinates
  `VTP_ASSERT(a_wzero_sat, (out_valid && out_data.clip_w_zero) |-> (x_sat && y_sat), "zero w")

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);

### sim/tb.sv
// testbench for the vertex transform, perspective divide and viewport block
`timescale 1ns / 100ps

import vtp_pkg::*;

// predicts screen positions and checks them against the block in order
class screen_pos_board;
  logic [63:0] mat_row[4];
  logic [13:0] vp_width;
  logic [13:0] vp_height;
  out_data_t   pending_pos[$];
  int          n_checked;
  int          n_wzero;
  int          n_errors;

  function new();
    mat_row[0] = 64'h0000_0000_0000_1000;
    mat_row[1] = 64'h0000_0000_1000_0000;
    mat_row[2] = 64'h0000_1000_0000_0000;
    mat_row[3] = 64'h1000_0000_0000_0000;
    vp_width   = 14'd320;
    vp_height  = 14'd200;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [63:0] value);
    case (idx) inside
      CFG_ROW0, CFG_ROW1, CFG_ROW2, CFG_ROW3: mat_row[idx] = value;
      CFG_VP_WIDTH:  vp_width  = value[13:0];
      CFG_VP_HEIGHT: vp_height = value[13:0];
      default: ;
    endcase
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // transform, divide and map one vertex
  function void note_vertex(in_data_t vtx);
    longint coord[4];
    longint clip[4];
    longint acc;
    longint ndcx, ndcy;
    logic signed [15:0] entry;
    out_data_t pos;
    coord[0] = vtx.vertex_x;
    coord[1] = vtx.vertex_y;
    coord[2] = vtx.vertex_z;
    coord[3] = vtx.vertex_w;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) begin
        entry = mat_row[r][16*c +: 16];
        acc += longint'(entry) * coord[c];
      end
      clip[r] = clamp32(acc / 4096);
    end
    if (clip[3] == 0) begin
      pos.screen_x    = clip[0] >= 0 ? S32_MAX : S32_MIN;
      pos.screen_y    = clip[1] >= 0 ? S32_MIN : S32_MAX;
      pos.clip_w_zero = 1'b1;
    end else begin
      ndcx = clamp32((clip[0] * 65536) / clip[3]);
      ndcy = clamp32((clip[1] * 65536) / clip[3]);
      pos.screen_x    = 32'(clamp32(((ndcx + 65536) * longint'(vp_width)) / 2));
      pos.screen_y    = 32'(clamp32(((65536 - ndcy) * longint'(vp_height)) / 2));
      pos.clip_w_zero = 1'b0;
    end
    pending_pos.push_back(pos);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  task check_pos(out_data_t got);
    out_data_t want;
    if (pending_pos.size() == 0) begin
      report_mismatch("unexpected transaction", got.screen_x, '0);
      return;
    end
    want = pending_pos.pop_front();
    n_checked++;
    if (want.clip_w_zero) n_wzero++;
    if (got.screen_x !== want.screen_x)
      report_mismatch("screen_x", got.screen_x, want.screen_x);
    if (got.screen_y !== want.screen_y)
      report_mismatch("screen_y", got.screen_y, want.screen_y);
    if (got.clip_w_zero !== want.clip_w_zero)
      report_mismatch("clip_w_zero", 32'(got.clip_w_zero), 32'(want.clip_w_zero));
  endtask
endclass

module tb;
  localparam int LATENCY = 55;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_data_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_data_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  screen_pos_board board;
  int          cycle_count;
  bit          long_stalls;

  vertex_transform_project u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("vertex_transform_project test failed");
      $finish;
    end
  end

  // result side: random stall, check each accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_pos(out_data);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < (long_stalls ? 60 : 20)) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // valid stays high between back-to-back transactions
  task send_vertex(in_data_t vtx, bit with_gaps);
    int gap;
    gap = with_gaps ? gap_len() : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= vtx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_vertex(vtx);
  endtask

  // valid stays high between consecutive register writes
  task write_cfg(cfg_idx_t idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, value);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (board.pending_pos.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 16'h2000)) - 16'sh1000);
    endcase
  endfunction

  task rand_matrix();
    logic [63:0] row;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) row[16*c +: 16] = rand_entry();
      write_cfg(cfg_idx_t'(r), row);
    end
  endtask

  task rand_vertex(bit with_gaps);
    in_data_t vtx;
    vtx.vertex_x = rand_coord();
    vtx.vertex_y = rand_coord();
    vtx.vertex_z = rand_coord();
    vtx.vertex_w = $urandom_range(0, 9) == 0 ? 32'h0 : rand_coord();
    send_vertex(vtx, with_gaps);
  endtask

  initial begin
    board       = new();
    cycle_count = 0;
    long_stalls = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_ROW0;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity matrix, field extremes and zero w
    send_vertex('{32'h0, 32'h0, 32'h0, 32'h0001_0000}, 0);
    send_vertex('{32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0001_0000}, 0);
    send_vertex('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
    send_vertex('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0);
    send_vertex('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0000_0001}, 0);
    send_vertex('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF}, 0);
    send_vertex('{32'h0000_5000, 32'h0000_3000, 32'h0, 32'h0}, 0);
    send_vertex('{32'hFFFF_5000, 32'hFFFF_3000, 32'h0, 32'h0}, 0);
    send_vertex('{32'h0, 32'hFFFF_3000, 32'h0, 32'h0}, 0);
    send_vertex('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0);
    drain();

    // directed: extreme matrix entries and viewport ends, including zero
    write_cfg(CFG_ROW0, 64'h7FFF_8000_7FFF_8000);
    write_cfg(CFG_ROW1, 64'h8000_7FFF_8000_7FFF);
    write_cfg(CFG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(CFG_ROW3, 64'h1000_0000_0000_0001);
    write_cfg(CFG_VP_WIDTH, 64'd8192);
    write_cfg(CFG_VP_HEIGHT, 64'd0);
    send_vertex('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0001_0000}, 0);
    send_vertex('{32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0}, 0);
    send_vertex('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF}, 0);
    drain();
    write_cfg(CFG_VP_WIDTH, 64'h3FFF);
    write_cfg(CFG_VP_HEIGHT, 64'd1);
    send_vertex('{32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h0001_0000}, 0);
    send_vertex('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000}, 0);
    drain();

    // random phases, each with its own matrix and viewport
    for (int ph = 0; ph < 8; ph++) begin
      long_stalls = (ph % 3 == 2);
      if (ph == 0) begin
        write_cfg(CFG_ROW0, 64'h0000_0000_0000_1000);
        write_cfg(CFG_ROW1, 64'h0000_0000_1000_0000);
        write_cfg(CFG_ROW2, 64'h0000_1000_0000_0000);
        write_cfg(CFG_ROW3, 64'h1000_0000_0000_0000);
      end else begin
        rand_matrix();
      end
      write_cfg(CFG_VP_WIDTH, ph == 3 ? 64'd1 : 64'($urandom_range(0, 16383)));
      write_cfg(CFG_VP_HEIGHT, ph == 4 ? 64'd8192 : 64'($urandom_range(0, 16383)));
      for (int i = 0; i < 60; i++) begin
        rand_vertex(ph != 1);
        // hold off until the pipeline empties
        if (ph == 5 && i == 30) begin
          in_valid <= 1'b0;
          while (board.pending_pos.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("checked %0d screen positions, %0d with zero clip w, over 8 random setups",
             board.n_checked, board.n_wzero);
    if (board.n_errors == 0 && board.pending_pos.size() == 0) begin
      $display("vertex_transform_project test passed");
    end else begin
      $display("vertex_transform_project test failed");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/vtp_pkg.sv
design/vtp_lane.sv
design/vtp_div.sv
design/vtp_vp.sv
design/vertex_transform_project.sv
design/vtp_checker.sv
sim/tb.sv
